// ===== hdl/qslerp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the quaternion slerp pipeline.
// No dependencies; the top level, the CORDIC modules and the testbench take names from here by scope.
package qslerp_pkg;

  localparam int unsigned ONE_Q14      = 16384;
  localparam logic [14:0] THR_RESET    = 15'd16382;
  localparam logic signed [27:0] INV_GAIN_Q24 = 28'sd10188014;

  // Item payload carried alongside the arithmetic through every stage.
  typedef struct packed {
    logic [3:0][15:0] a;
    logic [3:0][16:0] b;   // b after the shorter-arc negation, one bit wider
    logic [14:0]      t;   // blend clamped to one
    logic             linear;
  } side_t;

  // round(atan(2^-i) * 2^24)
  function automatic logic signed [26:0] atan_q24(input int unsigned idx);
    logic signed [26:0] v;
    v = '0;
    unique case (idx)
      0:  v = 27'sd13176795;
      1:  v = 27'sd7778716;
      2:  v = 27'sd4110060;
      3:  v = 27'sd2086331;
      4:  v = 27'sd1047214;
      5:  v = 27'sd524117;
      6:  v = 27'sd262123;
      7:  v = 27'sd131069;
      8:  v = 27'sd65536;
      9:  v = 27'sd32768;
      10: v = 27'sd16384;
      11: v = 27'sd8192;
      12: v = 27'sd4096;
      13: v = 27'sd2048;
      14: v = 27'sd1024;
      15: v = 27'sd512;
      16: v = 27'sd256;
      17: v = 27'sd128;
      18: v = 27'sd64;
      19: v = 27'sd32;
      20: v = 27'sd16;
      21: v = 27'sd8;
      22: v = 27'sd4;
      23: v = 27'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/qslerp_in_if.sv =====
`timescale 1ns / 1ps
// Input channel: two quaternions and a blend factor, valid/ready handshake.
// No dependencies.
interface qslerp_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] a_w;
  logic signed [15:0] a_x;
  logic signed [15:0] a_y;
  logic signed [15:0] a_z;
  logic signed [15:0] b_w;
  logic signed [15:0] b_x;
  logic signed [15:0] b_y;
  logic signed [15:0] b_z;
  logic        [14:0] blend;

  modport source (output valid, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, blend,
                  input ready);
  modport sink   (input valid, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, blend,
                  output ready);
endinterface

// ===== hdl/qslerp_out_if.sv =====
`timescale 1ns / 1ps
// Result channel: interpolated quaternion and path flag, valid/ready handshake.
// No dependencies.
interface qslerp_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] r_w;
  logic signed [15:0] r_x;
  logic signed [15:0] r_y;
  logic signed [15:0] r_z;
  logic               linear_used;

  modport source (output valid, r_w, r_x, r_y, r_z, linear_used, input ready);
  modport sink   (input valid, r_w, r_x, r_y, r_z, linear_used, output ready);
endinterface

// ===== hdl/quaternion_slerp.sv =====
`timescale 1ns / 1ps
// Fixed-point quaternion slerp: pipeline top level with dot product, weight
// mixing and output stages. Depends on qslerp_pkg, the two channel
// interfaces, qslerp_sqrt, qslerp_cordic_vec, qslerp_cordic_sin, qslerp_div.
//
// One item enters per clock while the pipeline is not frozen. The stages
// are, in order: three dot-product stages, a 29-stage square root, two
// CORDIC chains of CORDIC_STEPS stages each, one angle-scaling stage, a
// 31-stage weight divider and three mixing and output stages. The whole
// pipeline freezes when the output register holds an item that is not
// taken, so ready falls only then. Write near_threshold only while no item
// is in flight.
module quaternion_slerp #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [14:0] cfg_wdata_i,
  qslerp_in_if.sink   in_i,
  qslerp_out_if.source out_o
);
  localparam int SideW = $bits(qslerp_pkg::side_t);

  logic        adv;
  logic [14:0] thr_q;

  // Stage 1: component products
  logic                    v1_q;
  qslerp_pkg::side_t       side1_q;
  logic signed [31:0]      prod_q [4];
  logic [14:0]             t_clamp;

  // Stage 2: dot, shorter arc, path decision
  logic                    v2_q;
  qslerp_pkg::side_t       side2_q;
  logic [27:0]             dot2_q;
  logic signed [33:0]      dot_sum;
  logic [32:0]             dot_abs;
  logic [18:0]             cos14;
  logic                    lin_d;
  qslerp_pkg::side_t       side2_d;

  // Stage 3: radicand
  logic                    v3_q;
  qslerp_pkg::side_t       side3_q;
  logic [27:0]             dot3_q;
  logic [56:0]             rad3_q;
  logic [55:0]             dot_sq;

  // square root
  logic                    sq_vld;
  logic [28:0]             sq_root;
  logic [SideW+27:0]       sq_side;

  // vectoring CORDIC
  logic                    vec_vld;
  logic signed [26:0]      omega;
  logic [SideW+28:0]       vec_side;
  qslerp_pkg::side_t       vec_pl;

  // angle scaling
  logic                    va_q;
  logic signed [26:0]      ang_q [2];
  logic [SideW+28:0]       sa_side_q;
  logic signed [42:0]      ang_m0;
  logic signed [42:0]      ang_m1;

  // sine CORDIC
  logic                    sin_vld;
  logic signed [27:0]      sin_v [2];
  logic [SideW+28:0]       sin_side;

  // divider
  logic                    dv_vld;
  logic [30:0]             quo [2];
  logic                    qneg [2];
  logic [SideW-1:0]        dv_side;
  qslerp_pkg::side_t       dv_pl;

  // weight select, products, output
  logic                    vk_q;
  qslerp_pkg::side_t       sidek_q;
  logic signed [31:0]      k_q [2];
  logic signed [31:0]      k_d [2];
  logic                    vp_q;
  logic                    linp_q;
  logic signed [47:0]      pa_q [4];
  logic signed [48:0]      pb_q [4];
  logic                    out_vld_q;
  logic signed [15:0]      r_q [4];
  logic signed [15:0]      r_d [4];
  logic                    lin_out_q;

  assign adv        = !out_vld_q || out_o.ready;
  assign in_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= qslerp_pkg::THR_RESET;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // valid bits of the top-level stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      va_q      <= 1'b0;
      vk_q      <= 1'b0;
      vp_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      v1_q      <= in_i.valid;
      v2_q      <= v1_q;
      v3_q      <= v2_q;
      va_q      <= vec_vld;
      vk_q      <= dv_vld;
      vp_q      <= vk_q;
      out_vld_q <= vp_q;
    end
  end

  // ---- stage 1
  assign t_clamp = (in_i.blend > 15'(qslerp_pkg::ONE_Q14)) ?
                   15'(qslerp_pkg::ONE_Q14) : in_i.blend;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side1_q.a      <= {in_i.a_z, in_i.a_y, in_i.a_x, in_i.a_w};
      side1_q.b      <= {17'(in_i.b_z), 17'(in_i.b_y), 17'(in_i.b_x), 17'(in_i.b_w)};
      side1_q.t      <= t_clamp;
      side1_q.linear <= 1'b0;
      prod_q[0]      <= in_i.a_w * in_i.b_w;
      prod_q[1]      <= in_i.a_x * in_i.b_x;
      prod_q[2]      <= in_i.a_y * in_i.b_y;
      prod_q[3]      <= in_i.a_z * in_i.b_z;
    end
  end

  // ---- stage 2
  assign dot_sum = 34'(prod_q[0]) + 34'(prod_q[1]) + 34'(prod_q[2]) + 34'(prod_q[3]);
  assign dot_abs = dot_sum[33] ? 33'(-dot_sum) : 33'(dot_sum);
  assign cos14   = dot_abs[32:14];
  assign lin_d   = (cos14 > {4'b0, thr_q}) || (cos14 >= 19'(qslerp_pkg::ONE_Q14));

  always_comb begin
    side2_d        = side1_q;
    side2_d.linear = lin_d;
    // take the shorter arc
    for (int j = 0; j < 4; j++) begin
      if (dot_sum[33]) begin
        side2_d.b[j] = 17'(-$signed(side1_q.b[j]));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side2_q <= side2_d;
      dot2_q  <= dot_abs[27:0];
    end
  end

  // ---- stage 3: 1 - cos^2 in Q56 (only meaningful on the angular path)
  assign dot_sq = dot2_q * dot2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side3_q <= side2_q;
      dot3_q  <= dot2_q;
      rad3_q  <= {1'b1, 56'b0} - {1'b0, dot_sq};
    end
  end

  qslerp_sqrt #(
    .SIDE_W (SideW + 28)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v3_q),
    .rad_i   (rad3_q),
    .side_i  ({dot3_q, side3_q}),
    .valid_o (sq_vld),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  qslerp_cordic_vec #(
    .STEPS  (CORDIC_STEPS),
    .SIDE_W (SideW + 29)
  ) u_vec (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (sq_vld),
    .x_i     (sq_side[SideW+27:SideW]),
    .y_i     (sq_root),
    .side_i  ({sq_root, sq_side[SideW-1:0]}),
    .valid_o (vec_vld),
    .angle_o (omega),
    .side_o  (vec_side)
  );

  // ---- angle scaling: omega * (1 - t) and omega * t
  assign vec_pl = qslerp_pkg::side_t'(vec_side[SideW-1:0]);
  assign ang_m0 = omega * $signed({1'b0, 15'(qslerp_pkg::ONE_Q14) - vec_pl.t});
  assign ang_m1 = omega * $signed({1'b0, vec_pl.t});

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ang_q[0]  <= ang_m0[40:14];
      ang_q[1]  <= ang_m1[40:14];
      sa_side_q <= vec_side;
    end
  end

  qslerp_cordic_sin #(
    .STEPS  (CORDIC_STEPS),
    .SIDE_W (SideW + 29)
  ) u_sin (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (va_q),
    .ang_i   (ang_q),
    .side_i  (sa_side_q),
    .valid_o (sin_vld),
    .sin_o   (sin_v),
    .side_o  (sin_side)
  );

  qslerp_div #(
    .SIDE_W (SideW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (sin_vld),
    .s_i     (sin_v),
    .div_i   (sin_side[SideW+28:SideW]),
    .side_i  (sin_side[SideW-1:0]),
    .valid_o (dv_vld),
    .quo_o   (quo),
    .neg_o   (qneg),
    .side_o  (dv_side)
  );

  // ---- weight select
  assign dv_pl = qslerp_pkg::side_t'(dv_side);

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      k_d[l] = qneg[l] ? -$signed({1'b0, quo[l]}) : $signed({1'b0, quo[l]});
    end
    if (dv_pl.linear) begin
      k_d[0] = $signed(32'(15'(qslerp_pkg::ONE_Q14) - dv_pl.t));
      k_d[1] = $signed(32'(dv_pl.t));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      k_q     <= k_d;
      sidek_q <= dv_pl;
    end
  end

  // ---- weighted products
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int j = 0; j < 4; j++) begin
        pa_q[j] <= $signed(sidek_q.a[j]) * k_q[0];
        pb_q[j] <= $signed(sidek_q.b[j]) * k_q[1];
      end
      linp_q <= sidek_q.linear;
    end
  end

  // ---- round, saturate
  always_comb begin
    logic signed [49:0] acc;
    logic signed [35:0] rs;
    for (int j = 0; j < 4; j++) begin
      acc = 50'(pa_q[j]) + 50'(pb_q[j]) + 50'sd8192;
      rs  = acc[49:14];
      if (rs > 36'sd32767) begin
        r_d[j] = 16'sh7fff;
      end else if (rs < -36'sd32768) begin
        r_d[j] = -16'sh8000;
      end else begin
        r_d[j] = rs[15:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r_q       <= r_d;
      lin_out_q <= linp_q;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.r_w         = r_q[0];
  assign out_o.r_x         = r_q[1];
  assign out_o.r_y         = r_q[2];
  assign out_o.r_z         = r_q[3];
  assign out_o.linear_used = lin_out_q;

`ifndef SYNTHESIS
  // the angular path only sees a cosine below one
  a_angular_below_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && !lin_d |-> dot_abs < 33'h1000_0000)
    else $error("angular path taken with cosine of one or more");

  // sine of omega never zero where it is used as divisor; the linear flag is
  // the low bit of the payload
  a_sin_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_vld && !sq_side[0] |-> sq_root != '0)
    else $error("zero sine on angular path");

  // a waiting result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_o.ready |=> out_vld_q && $stable(r_q[0]) && $stable(lin_out_q))
    else $error("result changed while stalled");
`endif
endmodule

// ===== hdl/qslerp_sqrt.sv =====
`timescale 1ns / 1ps
// Pipelined restoring square root: one root bit per stage, 29 stages.
// Carries a side payload of SIDE_W bits in step. No package dependency.
module qslerp_sqrt #(
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [56:0]       rad_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [28:0]       root_o,
  output logic [SIDE_W-1:0] side_o
);
  localparam int Steps = 29;
  localparam int RadW  = 2 * Steps;
  localparam int RootW = Steps;
  localparam int RemW  = Steps + 2;

  logic [RadW-1:0]   rad_q  [Steps];
  logic [RemW-1:0]   rem_q  [Steps];
  logic [RootW-1:0]  root_q [Steps];
  logic [SIDE_W-1:0] side_q [Steps];
  logic              vld_q  [Steps];

  for (genvar k = 0; k < Steps; k++) begin : g_stage
    logic [RadW-1:0]   rad_in;
    logic [RemW-1:0]   rem_in;
    logic [RootW-1:0]  root_in;
    logic [SIDE_W-1:0] side_in;
    logic              vld_in;
    logic [RemW-1:0]   rem_t;
    logic [RemW-1:0]   trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign rad_in  = {1'b0, rad_i};
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign side_in = side_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    // bring down the next pair of radicand bits and try root*4+1
    assign rem_t = {rem_in[RemW-3:0], rad_in[RadW-1 -: 2]};
    assign trial = {root_in, 2'b01};
    assign ge    = rem_t >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k]  <= {rad_in[RadW-3:0], 2'b00};
        rem_q[k]  <= ge ? rem_t - trial : rem_t;
        root_q[k] <= {root_in[RootW-2:0], ge};
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[Steps-1];
  assign root_o  = root_q[Steps-1];
  assign side_o  = side_q[Steps-1];
endmodule

// ===== hdl/qslerp_cordic_vec.sv =====
`timescale 1ns / 1ps
// Vectoring CORDIC for atan2(y, x), one micro-rotation per stage.
// Uses qslerp_pkg::atan_q24; carries a side payload of SIDE_W bits.
module qslerp_cordic_vec #(
  parameter int STEPS  = 16,
  parameter int SIDE_W = 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [27:0]              x_i,
  input  logic [28:0]              y_i,
  input  logic [SIDE_W-1:0]        side_i,
  output logic                     valid_o,
  output logic signed [26:0]       angle_o,
  output logic [SIDE_W-1:0]        side_o
);
  logic signed [31:0] x_q    [STEPS];
  logic signed [31:0] y_q    [STEPS];
  logic signed [26:0] z_q    [STEPS];
  logic [SIDE_W-1:0]  side_q [STEPS];
  logic               vld_q  [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_stage
    logic signed [31:0] x_in;
    logic signed [31:0] y_in;
    logic signed [26:0] z_in;
    logic [SIDE_W-1:0]  side_in;
    logic               vld_in;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic               up;

    if (k == 0) begin : g_first
      assign x_in    = $signed({4'b0, x_i});
      assign y_in    = $signed({3'b0, y_i});
      assign z_in    = '0;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign x_in    = x_q[k-1];
      assign y_in    = y_q[k-1];
      assign z_in    = z_q[k-1];
      assign side_in = side_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    assign dx = y_in >>> k;
    assign dy = x_in >>> k;
    // rotate towards y = 0; y exactly zero counts as below
    assign up = !y_in[31] && (y_in != '0);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (up) begin
          x_q[k] <= x_in + dx;
          y_q[k] <= y_in - dy;
          z_q[k] <= z_in + qslerp_pkg::atan_q24(k);
        end else begin
          x_q[k] <= x_in - dx;
          y_q[k] <= y_in + dy;
          z_q[k] <= z_in - qslerp_pkg::atan_q24(k);
        end
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[STEPS-1];
  assign angle_o = z_q[STEPS-1];
  assign side_o  = side_q[STEPS-1];
endmodule

// ===== hdl/qslerp_cordic_sin.sv =====
`timescale 1ns / 1ps
// Two-lane rotation CORDIC giving the sine of two angles in lock step.
// Uses qslerp_pkg constants and arctangent table; carries SIDE_W side bits.
module qslerp_cordic_sin #(
  parameter int STEPS  = 16,
  parameter int SIDE_W = 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic signed [26:0] ang_i [2],
  input  logic [SIDE_W-1:0]  side_i,
  output logic               valid_o,
  output logic signed [27:0] sin_o [2],
  output logic [SIDE_W-1:0]  side_o
);
  logic signed [27:0] x_q    [2][STEPS];
  logic signed [27:0] y_q    [2][STEPS];
  logic signed [27:0] z_q    [2][STEPS];
  logic [SIDE_W-1:0]  side_q [STEPS];
  logic               vld_q  [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_stage
    logic [SIDE_W-1:0] side_in;
    logic              vld_in;

    if (k == 0) begin : g_first
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign side_in = side_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k] <= side_in;
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic signed [27:0] x_in;
      logic signed [27:0] y_in;
      logic signed [27:0] z_in;
      logic signed [27:0] dx;
      logic signed [27:0] dy;
      logic signed [27:0] at;

      if (k == 0) begin : g_first
        assign x_in = qslerp_pkg::INV_GAIN_Q24;
        assign y_in = '0;
        assign z_in = 28'(ang_i[l]);
      end else begin : g_next
        assign x_in = x_q[l][k-1];
        assign y_in = y_q[l][k-1];
        assign z_in = z_q[l][k-1];
      end

      assign dx = y_in >>> k;
      assign dy = x_in >>> k;
      assign at = 28'(qslerp_pkg::atan_q24(k));

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          if (!z_in[27]) begin
            x_q[l][k] <= x_in - dx;
            y_q[l][k] <= y_in + dy;
            z_q[l][k] <= z_in - at;
          end else begin
            x_q[l][k] <= x_in + dx;
            y_q[l][k] <= y_in - dy;
            z_q[l][k] <= z_in + at;
          end
        end
      end
    end
  end

  assign valid_o  = vld_q[STEPS-1];
  assign sin_o[0] = y_q[0][STEPS-1];
  assign sin_o[1] = y_q[1][STEPS-1];
  assign side_o   = side_q[STEPS-1];
endmodule

// ===== hdl/qslerp_div.sv =====
`timescale 1ns / 1ps
// Two-lane pipelined restoring divider: |s| * 2^18 / d, one quotient bit per
// stage, 31 stages, sign returned beside the magnitude. No package dependency.
module qslerp_div #(
  parameter int SIDE_W = 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic signed [27:0] s_i [2],
  input  logic [28:0]        div_i,
  input  logic [SIDE_W-1:0]  side_i,
  output logic               valid_o,
  output logic [30:0]        quo_o [2],
  output logic               neg_o [2],
  output logic [SIDE_W-1:0]  side_o
);
  localparam int QuoW = 31;
  localparam int DvdW = 46;
  localparam int RemW = 29;

  logic [RemW-1:0]   rem_q  [2][QuoW];
  logic [QuoW-1:0]   lo_q   [2][QuoW];
  logic [QuoW-1:0]   quo_q  [2][QuoW];
  logic              neg_q  [2][QuoW];
  logic [RemW-1:0]   div_q  [QuoW];
  logic [SIDE_W-1:0] side_q [QuoW];
  logic              vld_q  [QuoW];

  for (genvar k = 0; k < QuoW; k++) begin : g_stage
    logic [RemW-1:0]   div_in;
    logic [SIDE_W-1:0] side_in;
    logic              vld_in;

    if (k == 0) begin : g_first
      assign div_in  = div_i;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign div_in  = div_q[k-1];
      assign side_in = side_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        div_q[k]  <= div_in;
        side_q[k] <= side_in;
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [RemW-1:0] rem_in;
      logic [QuoW-1:0] lo_in;
      logic [QuoW-1:0] quo_in;
      logic            neg_in;
      logic [RemW:0]   rem_t;
      logic            ge;

      if (k == 0) begin : g_first
        logic [27:0]     mag;
        logic [DvdW-1:0] dvd;
        assign mag    = s_i[l][27] ? 28'(-s_i[l]) : 28'(s_i[l]);
        assign dvd    = {mag, 18'b0};
        assign rem_in = RemW'(dvd[DvdW-1:QuoW]);
        assign lo_in  = dvd[QuoW-1:0];
        assign quo_in = '0;
        assign neg_in = s_i[l][27];
      end else begin : g_next
        assign rem_in = rem_q[l][k-1];
        assign lo_in  = lo_q[l][k-1];
        assign quo_in = quo_q[l][k-1];
        assign neg_in = neg_q[l][k-1];
      end

      assign rem_t = {rem_in, lo_in[QuoW-1]};
      assign ge    = rem_t >= {1'b0, div_in};

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[l][k] <= ge ? RemW'(rem_t - {1'b0, div_in}) : RemW'(rem_t);
          lo_q[l][k]  <= {lo_in[QuoW-2:0], 1'b0};
          quo_q[l][k] <= {quo_in[QuoW-2:0], ge};
          neg_q[l][k] <= neg_in;
        end
      end
    end
  end

  assign valid_o  = vld_q[QuoW-1];
  assign quo_o[0] = quo_q[0][QuoW-1];
  assign quo_o[1] = quo_q[1][QuoW-1];
  assign neg_o[0] = neg_q[0][QuoW-1];
  assign neg_o[1] = neg_q[1][QuoW-1];
  assign side_o   = side_q[QuoW-1];
endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for quaternion_slerp: drives request items through the input
// channel, predicts each result in fixed point and checks it field by field.
// Depends on qslerp_pkg, qslerp_in_if, qslerp_out_if and the RTL top level.
module tb_top;

  localparam int STEPS   = 16;
  localparam int LATENCY = 67 + 2 * STEPS;
  localparam int WDOG    = 20000;

  typedef struct {
    logic signed [15:0] q [8];
    logic [14:0]        blend;
  } request_t;

  typedef struct {
    logic signed [15:0] r [4];
    logic               linear_used;
  } slerp_t;

  // Q24 arctangent table.
  localparam longint ATAN_TAB [24] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2};

  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned r, bt;
    r = 0;
    bt = 64'd1 << 62;
    while (bt > n) bt >>= 2;
    while (bt != 0) begin
      if (n >= r + bt) begin
        n -= r + bt;
        r = (r >> 1) + bt;
      end else begin
        r >>= 1;
      end
      bt >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint vec_angle(longint y, longint x);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < STEPS && i < 24; i++) begin
      dx = fshr(y, i);
      dy = fshr(x, i);
      if (y > 0) begin
        x += dx; y -= dy; z += ATAN_TAB[i];
      end else begin
        x -= dx; y += dy; z -= ATAN_TAB[i];
      end
    end
    return z;
  endfunction

  function automatic longint rot_sine(longint z);
    longint x, y, dx, dy;
    x = 10188014;
    y = 0;
    for (int i = 0; i < STEPS && i < 24; i++) begin
      dx = fshr(y, i);
      dy = fshr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_TAB[i];
      end else begin
        x += dx; y -= dy; z += ATAN_TAB[i];
      end
    end
    return y;
  endfunction

  function automatic slerp_t predict_slerp(request_t rq, logic [14:0] thr);
    slerp_t res;
    longint a [4], b [4];
    longint dot, c14, t, k0, k1, s28, om, s0, s1, acc;
    longint unsigned d;
    dot = 0;
    for (int j = 0; j < 4; j++) begin
      a[j] = rq.q[j];
      b[j] = rq.q[4 + j];
      dot += a[j] * b[j];
    end
    t = rq.blend;
    if (t > qslerp_pkg::ONE_Q14) t = qslerp_pkg::ONE_Q14;
    if (dot < 0) begin
      for (int j = 0; j < 4; j++) b[j] = -b[j];
      dot = -dot;
    end
    c14 = dot >>> 14;
    res.linear_used = (c14 > longint'(thr)) || (c14 >= qslerp_pkg::ONE_Q14);
    if (res.linear_used) begin
      k0 = qslerp_pkg::ONE_Q14 - t;
      k1 = t;
    end else begin
      d = dot;
      s28 = int_sqrt((64'd1 << 56) - d * d);
      om = vec_angle(s28, dot);
      s0 = rot_sine(fshr(om * (qslerp_pkg::ONE_Q14 - t), 14));
      s1 = rot_sine(fshr(om * t, 14));
      k0 = (s0 * 262144) / s28;
      k1 = (s1 * 262144) / s28;
    end
    for (int j = 0; j < 4; j++) begin
      acc = fshr(a[j] * k0 + b[j] * k1 + 8192, 14);
      if (acc > 32767) acc = 32767;
      if (acc < -32768) acc = -32768;
      res.r[j] = acc[15:0];
    end
    return res;
  endfunction

  class slerp_board;
    slerp_t      pending [$];
    logic [14:0] thr = qslerp_pkg::THR_RESET;
    int          errors = 0;

    function void note_request(request_t rq);
      pending.push_back(predict_slerp(rq, thr));
    endfunction

    function void check_result(slerp_t got);
      slerp_t exp_r;
      string nm [4] = '{"r_w", "r_x", "r_y", "r_z"};
      if (pending.size() == 0) begin
        $error("unexpected result item");
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      for (int j = 0; j < 4; j++)
        if (got.r[j] !== exp_r.r[j]) begin
          $error("%s: expected %0d, got %0d", nm[j], exp_r.r[j], got.r[j]);
          errors++;
        end
      if (got.linear_used !== exp_r.linear_used) begin
        $error("linear_used: expected %0b, got %0b", exp_r.linear_used,
               got.linear_used);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [14:0] cfg_wdata_i = '0;
  int          idle_cycles = 0;
  slerp_board  board;

  qslerp_in_if  in_ch ();
  qslerp_out_if out_ch ();

  quaternion_slerp #(.CORDIC_STEPS(STEPS)) dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_i(in_ch), .out_o(out_ch)
  );

  always #10 clk_i = ~clk_i;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.a_w = '0; in_ch.a_x = '0; in_ch.a_y = '0; in_ch.a_z = '0;
    in_ch.b_w = '0; in_ch.b_x = '0; in_ch.b_y = '0; in_ch.b_z = '0;
    in_ch.blend = '0;
    out_ch.ready = 1'b0;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Result side: random stalls, with long stretches always ready.
  logic stall_free = 1'b0;
  always @(posedge clk_i) begin
    slerp_t got;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        got.r[0] = out_ch.r_w; got.r[1] = out_ch.r_x;
        got.r[2] = out_ch.r_y; got.r[3] = out_ch.r_z;
        got.linear_used = out_ch.linear_used;
        board.check_result(got);
      end
      if ($urandom_range(0, 199) == 0) stall_free <= ~stall_free;
      out_ch.ready <= stall_free || (gap_len() == 0);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk_i)
    if (idle_cycles >= WDOG) begin
      $display("Simulation FAILED");
      $finish;
    end

  // Hold valid across back-to-back items; drop it only before a gap.
  task automatic send_request(request_t rq, bit no_gap);
    int g;
    g = no_gap ? 0 : gap_len();
    if (g != 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.a_w <= rq.q[0]; in_ch.a_x <= rq.q[1];
    in_ch.a_y <= rq.q[2]; in_ch.a_z <= rq.q[3];
    in_ch.b_w <= rq.q[4]; in_ch.b_x <= rq.q[5];
    in_ch.b_y <= rq.q[6]; in_ch.b_z <= rq.q[7];
    in_ch.blend <= rq.blend;
    do @(posedge clk_i); while (!in_ch.ready);
    board.note_request(rq);
  endtask

  // Stop driving, wait for the pipeline to drain, then hold.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [14:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.thr = v;
  endtask

  function automatic request_t rand_request(int kind);
    request_t rq;
    int r;
    for (int j = 0; j < 8; j++) begin
      r = $urandom_range(0, 9);
      if (kind == 0 || r == 0) rq.q[j] = 16'($urandom());
      else rq.q[j] = 16'($urandom_range(0, 16384) - 8192);
    end
    // Nearby quaternions stress the near-threshold region.
    if (kind == 2)
      for (int j = 0; j < 4; j++)
        rq.q[4 + j] = rq.q[j] + $signed(16'($urandom_range(0, 64) - 32));
    r = $urandom_range(0, 9);
    if (r == 0) rq.blend = 15'($urandom());
    else if (r == 1) rq.blend = 15'd16384;
    else if (r == 2) rq.blend = 15'd0;
    else rq.blend = 15'($urandom_range(0, 16384));
    return rq;
  endfunction

  task automatic random_phase(int n);
    request_t rq;
    for (int i = 0; i < n; i++) begin
      rq = rand_request($urandom_range(0, 2));
      send_request(rq, 1'b0);
    end
  endtask

  initial begin
    request_t rq;
    logic signed [15:0] ext [6] = '{16'sh7fff, -16'sh8000, 16'sd16384,
                                    -16'sd16384, 16'sd0, 16'sd11585};
    board = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, negative and zero dot, equal inputs, blend above one.
    for (int i = 0; i < 6; i++) begin
      for (int j = 0; j < 8; j++) rq.q[j] = ext[(i + j) % 6];
      rq.blend = (i % 3 == 0) ? 15'h7fff : ((i % 3 == 1) ? 15'd0 : 15'd16384);
      send_request(rq, 1'b1);
    end
    rq.q = '{16384, 0, 0, 0, 16384, 0, 0, 0}; rq.blend = 15'd8192;
    send_request(rq, 1'b1);
    rq.q = '{16384, 0, 0, 0, -16384, 0, 0, 0}; rq.blend = 15'd4096;
    send_request(rq, 1'b1);
    rq.q = '{16384, 0, 0, 0, 0, 16384, 0, 0}; rq.blend = 15'd8192;
    send_request(rq, 1'b1);
    rq.q = '{11585, 11585, 0, 0, 16384, 0, 0, 0}; rq.blend = 15'd12000;
    send_request(rq, 1'b1);
    rq.q = '{16384, 0, 0, 0, 16383, 181, 0, 0}; rq.blend = 15'd16383;
    send_request(rq, 1'b1);
    rq.q = '{-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767};
    rq.blend = 15'd1;
    send_request(rq, 1'b1);
    random_phase(100);

    drain();
    write_threshold(15'd0);
    random_phase(80);
    drain();
    write_threshold(15'd16384);
    random_phase(80);
    drain();
    write_threshold(15'h7fff);
    random_phase(60);
    drain();
    write_threshold(15'd15000);
    random_phase(80);
    drain();

    if (board.errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
